// File: rtl/floyd_steinberg_dither_top_assert.svh
// Assertion macros used by the dither top level.
`ifndef FLOYD_STEINBERG_DITHER_TOP_ASSERT_SVH
`define FLOYD_STEINBERG_DITHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FSD_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fsd_pkg.sv
// Shared types and constants of the dither block.
package fsd_pkg;

   localparam int PIX_W  = 8;
   localparam int CFG_W  = 12;
   localparam int DATA_W = 32;
   localparam int CSR_AW = 3;
   localparam int SUM_W  = 13;
   localparam int VAL_W  = 11;

   localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 12'd640;
   localparam logic [0:0]       ROW_WIDTH_IDX   = 1'b0;

   typedef logic signed [7:0]       err_type;
   typedef logic signed [8:0]       qerr_type;
   typedef logic signed [SUM_W-1:0] prod_type;
   typedef logic signed [VAL_W-1:0] val_type;

   typedef struct packed {
      logic frame_start;
      logic first_row;
      logic last_col;
   } pix_ctl_type;

   typedef struct packed {
      logic wr_en;
      logic tail_en;
   } mem_wr_type;

   // divide by 16, truncating toward zero
   function automatic err_type trunc16(prod_type p);
      prod_type adj;
      adj = p + (p[SUM_W-1] ? prod_type'(15) : prod_type'(0));
      return err_type'(adj >>> 4);
   endfunction

endpackage

// File: rtl/fsd_if.sv
// Stream channel interfaces: pixel requests and dithered responses.
interface fsd_req_if
   import fsd_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic             frame_start;

   modport source (output valid, output red, output green, output blue,
                   output frame_start, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input frame_start, output ready);
endinterface

interface fsd_rsp_if;
   logic valid;
   logic ready;
   logic white;
   logic row_end;

   modport source (output valid, output white, output row_end, input ready);
   modport sink   (input valid, input white, input row_end, output ready);
endinterface

// File: rtl/floyd_steinberg_dither_top.sv
// Top level of the Floyd-Steinberg RGB to one-bit dither block.
//
//   port     direction  handshake          payload
//   req_ch   in         valid/ready        red, green, blue, frame_start
//   rsp_ch   out        valid/ready        white, row_end
//   apb      in         psel/penable       row_width at byte address 0
//
// One item per clock sustained while rsp_ch does not stall; an accepted item
// passes the diffusion stage, then the output register, before rsp_ch.valid
// rises. The pace is set by the right-neighbor error loop, closed within the
// diffusion stage, and by the single write port of the row error memory.
// Reset is synchronous; the error memory is not cleared (rows are written
// before they are read). A stall on rsp_ch holds the output register, then the
// diffusion stage, and only then drops req_ch.ready.
`include "floyd_steinberg_dither_top_assert.svh"

module floyd_steinberg_dither_top
   import fsd_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
)(
   input  logic              clock,
   input  logic              reset,
   fsd_req_if.sink           req_ch,
   fsd_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

   logic [CFG_W-1:0] row_width;

   // front: column tracking and memory read issue
   logic [CW-1:0] col_ff, col_in, col_cur;
   logic          first_ff, first_in, first_cur;
   logic          last_cur;
   logic          req_accept;

   // diffusion stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_adv;
   logic [PIX_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   pix_ctl_type      s1_ctl_ff;
   logic [CW-1:0]    s1_col_ff;

   // output register
   logic out_valid_ff, out_valid_in;
   logic out_white_ff, out_row_end_ff;

   err_type    below;
   logic       white;
   mem_wr_type wr_ctl;
   logic [CW-1:0] wr_addr, tail_addr;
   err_type    wr_data, tail_data;

   fsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .row_width (row_width)
   );

   // Advance the diffusion stage when the output register is free or drains now.
   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Frame start restarts the row; a width of zero acts as one and
   // anything past MAX_WIDTH is capped there.
   always_comb begin
      col_cur   = req_ch.frame_start ? '0 : col_ff;
      first_cur = req_ch.frame_start | first_ff;
      last_cur  = (LW'(col_cur) + LW'(1) >= LW'(row_width))
               || (LW'(col_cur) + LW'(1) >= LW'(MAX_WIDTH));
   end

   always_comb begin
      col_in   = col_ff;
      first_in = first_ff;
      if (req_accept) begin
         col_in   = last_cur ? '0 : col_cur + CW'(1);
         first_in = last_cur ? 1'b0 : first_cur;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         first_ff     <= first_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on accept, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_red_ff             <= req_ch.red;
         s1_green_ff           <= req_ch.green;
         s1_blue_ff            <= req_ch.blue;
         s1_col_ff             <= col_cur;
         s1_ctl_ff.frame_start <= req_ch.frame_start;
         s1_ctl_ff.first_row   <= first_cur;
         s1_ctl_ff.last_col    <= last_cur;
      end
      if (s1_adv) begin
         out_white_ff   <= white;
         out_row_end_ff <= s1_ctl_ff.last_col;
      end
   end

   // Read the error left by the row above for this column.
   fsd_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr   (col_cur),
      .rd_data   (below),
      .wr_ctl    (wr_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .tail_addr (tail_addr),
      .tail_data (tail_data)
   );

   fsd_diffuse #(
      .AW (CW)
   ) u_diffuse (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_adv),
      .red       (s1_red_ff),
      .green     (s1_green_ff),
      .blue      (s1_blue_ff),
      .ctl       (s1_ctl_ff),
      .col       (s1_col_ff),
      .below     (below),
      .white     (white),
      .wr_ctl    (wr_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .tail_addr (tail_addr),
      .tail_data (tail_data)
   );

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.white   = out_white_ff;
   assign rsp_ch.row_end = out_row_end_ff;

   `FSD_ASSERT_NEXT(a_row_wrap, clock, reset, req_accept && last_cur, col_ff == '0, "column did not wrap after a row end")
   `FSD_ASSERT_NEXT(a_tail_slot, clock, reset, s1_adv && s1_ctl_ff.last_col, !s1_valid_ff || (s1_col_ff == '0), "item after a row end is not at column zero")
   `FSD_ASSERT_HOLDS(a_out_hold, clock, reset, out_valid_ff && !rsp_ch.ready, !s1_adv, "diffusion stage advanced over a held result")

endmodule

// File: rtl/fsd_csr.sv
// APB register file holding the row width.
module fsd_csr
   import fsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [CFG_W-1:0]  row_width
);

   logic [CFG_W-1:0] row_width_ff;
   logic [CFG_W-1:0] row_width_in;
   logic             hit;

   // byte offset bits are ignored
   assign hit    = (paddr[CSR_AW-1:2] == ROW_WIDTH_IDX);
   assign pready = 1'b1;
   assign prdata = hit ? DATA_W'(row_width_ff) : '0;

   always_comb begin
      row_width_in = row_width_ff;
      if (psel && penable && pwrite && hit) begin
         row_width_in = pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
      end else begin
         row_width_ff <= row_width_in;
      end
   end

   assign row_width = row_width_ff;

endmodule

// File: rtl/fsd_line_mem.sv
// Row error memory with deferred tail write and read forwarding.
module fsd_line_mem
   import fsd_pkg::*;
#(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output err_type       rd_data,
   input  mem_wr_type    wr_ctl,
   input  logic [AW-1:0] wr_addr,
   input  err_type       wr_data,
   input  logic [AW-1:0] tail_addr,
   input  err_type       tail_data
);

   err_type       mem [DEPTH];
   err_type       q_ff;
   logic          tail_pend_ff;
   logic [AW-1:0] tail_addr_ff;
   err_type       tail_data_ff;
   logic          fwd_hit_ff;
   logic          fwd_hit_in;
   err_type       fwd_data_ff;
   err_type       fwd_data_in;

   logic          port_we;
   logic [AW-1:0] port_addr;
   err_type       port_data;
   logic          hit_new;
   logic          hit_port;

   // the tail write lands in the cycle after a row end, when no normal write can occur
   assign port_we   = wr_ctl.wr_en | tail_pend_ff;
   assign port_addr = tail_pend_ff ? tail_addr_ff : wr_addr;
   assign port_data = tail_pend_ff ? tail_data_ff : wr_data;

   assign hit_new  = wr_ctl.tail_en && (tail_addr == rd_addr);
   assign hit_port = port_we && (port_addr == rd_addr);

   always_comb begin
      fwd_hit_in  = hit_new | hit_port;
      fwd_data_in = hit_new ? tail_data : port_data;
   end

   always_ff @(posedge clock) begin
      if (port_we) begin
         mem[port_addr] <= port_data;
      end
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         fwd_data_ff <= fwd_data_in;
      end
      if (wr_ctl.tail_en) begin
         tail_addr_ff <= tail_addr;
         tail_data_ff <= tail_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_pend_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         tail_pend_ff <= wr_ctl.tail_en;
         if (rd_en) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : q_ff;

endmodule

// File: rtl/fsd_diffuse.sv
// Gray conversion, quantization and error spreading for one pixel.
module fsd_diffuse
   import fsd_pkg::*;
#(
   parameter int AW = 11
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [PIX_W-1:0] red,
   input  logic [PIX_W-1:0] green,
   input  logic [PIX_W-1:0] blue,
   input  pix_ctl_type      ctl,
   input  logic [AW-1:0]    col,
   input  err_type          below,
   output logic             white,
   output mem_wr_type       wr_ctl,
   output logic [AW-1:0]    wr_addr,
   output err_type          wr_data,
   output logic [AW-1:0]    tail_addr,
   output err_type          tail_data
);

   err_type  right_ff, right_in;
   err_type  pend_left_ff, pend_left_in;
   err_type  pend_here_ff, pend_here_in;

   err_type          right_eff, pend_left_eff, pend_here_eff, below_eff;
   logic [SUM_W-1:0] gray_sum;
   logic [PIX_W-1:0] gray;
   val_type          val;
   logic [PIX_W-1:0] clamped;
   qerr_type         qerr;
   err_type          e7, e5, e3, e1;

   always_comb begin
      // frame start clears the running error before this pixel
      right_eff     = ctl.frame_start ? err_type'(0) : right_ff;
      pend_left_eff = ctl.frame_start ? err_type'(0) : pend_left_ff;
      pend_here_eff = ctl.frame_start ? err_type'(0) : pend_here_ff;
      below_eff     = ctl.first_row   ? err_type'(0) : below;

      gray_sum = SUM_W'(red) * SUM_W'(11) + SUM_W'(green) * SUM_W'(16)
               + SUM_W'(blue) * SUM_W'(5);
      gray     = gray_sum[SUM_W-1:5];

      val = val_type'({1'b0, gray}) + val_type'(right_eff) + val_type'(below_eff);
      if (val[VAL_W-1]) begin
         clamped = '0;
      end else if (val > val_type'(255)) begin
         clamped = '1;
      end else begin
         clamped = val[PIX_W-1:0];
      end

      white = clamped[PIX_W-1];
      qerr  = qerr_type'({1'b0, clamped}) - (white ? qerr_type'(255) : qerr_type'(0));

      e7 = trunc16(prod_type'(qerr) * prod_type'(7));
      e5 = trunc16(prod_type'(qerr) * prod_type'(5));
      e3 = trunc16(prod_type'(qerr) * prod_type'(3));
      e1 = trunc16(prod_type'(qerr));
   end

   assign wr_ctl.wr_en   = advance && (col != '0);
   assign wr_ctl.tail_en = advance && ctl.last_col;
   assign wr_addr        = col - AW'(1);
   assign wr_data        = pend_left_eff + e3;
   assign tail_addr      = col;
   assign tail_data      = pend_here_eff + e5;

   always_comb begin
      right_in     = right_ff;
      pend_left_in = pend_left_ff;
      pend_here_in = pend_here_ff;
      if (advance) begin
         if (ctl.last_col) begin
            right_in     = '0;
            pend_left_in = '0;
            pend_here_in = '0;
         end else begin
            right_in     = e7;
            pend_left_in = pend_here_eff + e5;
            pend_here_in = e1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff     <= '0;
         pend_left_ff <= '0;
         pend_here_ff <= '0;
      end else begin
         right_ff     <= right_in;
         pend_left_ff <= pend_left_in;
         pend_here_ff <= pend_here_in;
      end
   end

endmodule

// File: tb/fsd_dither_checker.sv
// Checker for the dither block: predicts each dithered pixel and compares responses.
`timescale 1ns / 1ps

module fsd_dither_checker
   import fsd_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
)(
   input  logic              clock,
   input  logic              reset,
   fsd_req_if                req_mon,
   fsd_rsp_if                rsp_mon,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   input  logic              pready,
   output int                mismatch_count,
   output int                outstanding
);

   localparam logic [CSR_AW-1:0] ROW_WIDTH_ADDR = CSR_AW'(ROW_WIDTH_IDX) << 2;

   typedef struct packed {
      logic white;
      logic row_end;
   } dot_type;

   dot_type          expected_dots[$];
   err_type          next_row_err [MAX_WIDTH];
   logic [CFG_W-1:0] width_reg;
   int unsigned      col_pos;
   bit               top_row;
   int               carry_right;
   int               carry_left;
   int               carry_here;

   initial mismatch_count = 0;
   initial outstanding = 0;

   function automatic void clear_row();
      col_pos = 0;
      carry_right = 0;
      carry_left = 0;
      carry_here = 0;
   endfunction

   function automatic dot_type dither_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic fs);
      int unsigned span;
      bit          last;
      int          level;
      int          err;
      int          e7;
      int          e5;
      int          e3;
      int          e1;
      dot_type     dot;
      span = (width_reg == '0) ? 1 :
             ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      if (fs) begin
         clear_row();
         top_row = 1'b1;
      end
      if (col_pos >= MAX_WIDTH) col_pos = 0;
      last = (col_pos + 1 >= span);
      level = (11 * int'(r) + 16 * int'(g) + 5 * int'(b)) / 32 + carry_right;
      if (!top_row) level += int'(next_row_err[col_pos]);
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      dot.white = (level >= 128);
      dot.row_end = last;
      err = level - (dot.white ? 255 : 0);
      // integer division truncates toward zero, as the spread requires
      e7 = err * 7 / 16;
      e5 = err * 5 / 16;
      e3 = err * 3 / 16;
      e1 = err / 16;
      if (col_pos > 0) next_row_err[col_pos - 1] = err_type'(carry_left + e3);
      if (last) begin
         next_row_err[col_pos] = err_type'(carry_here + e5);
         clear_row();
         top_row = 1'b0;
      end else begin
         carry_left = carry_here + e5;
         carry_here = e1;
         carry_right = e7;
         col_pos++;
      end
      return dot;
   endfunction

   function automatic void note_mismatch(string msg);
      if (mismatch_count < 10) $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endfunction

   always @(posedge clock) begin
      dot_type got;
      dot_type want;
      if (reset) begin
         expected_dots.delete();
         width_reg = ROW_WIDTH_RESET;
         clear_row();
         top_row = 1'b1;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ROW_WIDTH_ADDR)
            width_reg = pwdata[CFG_W-1:0];
         if (req_mon.valid && req_mon.ready)
            expected_dots.push_back(dither_pixel(req_mon.red, req_mon.green, req_mon.blue,
                                                 req_mon.frame_start));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.white = rsp_mon.white;
            got.row_end = rsp_mon.row_end;
            if (expected_dots.size() == 0) begin
               note_mismatch($sformatf("unexpected pixel white=%b row_end=%b",
                                       got.white, got.row_end));
            end else begin
               want = expected_dots.pop_front();
               if (got.white !== want.white)
                  note_mismatch($sformatf("white: expected %b, got %b",
                                          want.white, got.white));
               if (got.row_end !== want.row_end)
                  note_mismatch($sformatf("row_end: expected %b, got %b",
                                          want.row_end, got.row_end));
            end
         end
      end
      outstanding <= expected_dots.size();
   end

endmodule

// File: tb/tb.sv
// Top of the dither testbench: clock, reset, pixel stimulus, row width writes and verdict.
`timescale 1ns / 1ps

module tb;
   import fsd_pkg::*;

   localparam int MAX_WIDTH = 2048;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [CSR_AW-1:0] ROW_WIDTH_ADDR = CSR_AW'(ROW_WIDTH_IDX) << 2;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int          mismatch_count;
   int          outstanding;
   int          idle_cycles = 0;
   // effective width of the current setting; a wider one needs a fresh frame
   int unsigned cur_span = ROW_WIDTH_RESET;
   bit          force_frame = 1'b0;
   bit          feed_gaps = 1'b1;
   bit          drain_stalls = 1'b1;
   int          long_hold_len = 0;

   fsd_req_if req_ch ();
   fsd_rsp_if rsp_ch ();

   always #4 clock = ~clock;

   floyd_steinberg_dither_top #(.MAX_WIDTH(MAX_WIDTH)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   fsd_dither_checker #(.MAX_WIDTH(MAX_WIDTH)) dot_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Watchdog: end the run if nothing moves on any port for too long.
   // The long receiver hold-off is far below the limit.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("floyd_steinberg_dither_top test failed");
            $finish;
         end
      end
   end

   // Map a register value to the row length the block really uses.
   function automatic int unsigned span_of(logic [CFG_W-1:0] w);
      if (w == '0) return 1;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   // Offer one pixel, after a random gap if feed_gaps is set, and hold it
   // until it is taken. Valid stays high after the handshake; the next call
   // either reloads it or drops it, so it is written once per step.
   task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      int gap;
      gap = feed_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.red <= r;
      req_ch.green <= g;
      req_ch.blue <= b;
      req_ch.frame_start <= fs | force_frame;
      force_frame = 1'b0;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Draw a pixel from a mix of shapes: uniform, near the threshold, saturated,
   // dark and bright, so that errors of both signs build up and clamp.
   task automatic push_random(logic fs);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      int         v;
      case ($urandom_range(0, 9))
         5, 6: begin
            v = $urandom_range(118, 138);
            r = 8'(v + $urandom_range(0, 2));
            g = 8'(v);
            b = 8'(v - $urandom_range(0, 2));
         end
         7: begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         8: begin
            r = 8'($urandom_range(0, 40));
            g = 8'($urandom_range(0, 40));
            b = 8'($urandom_range(0, 40));
         end
         9: begin
            r = 8'($urandom_range(215, 255));
            g = 8'($urandom_range(215, 255));
            b = 8'($urandom_range(215, 255));
         end
         default: begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
         end
      endcase
      push_pixel(r, g, b, fs);
   endtask

   // Drop valid and hold until every predicted pixel has come back.
   // The count is registered, so it is tested only after it has been updated.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic apb_write(logic [CSR_AW-1:0] addr, logic [DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Change the row width with the block idle. Widening without a new frame
   // would read error entries that no row ever wrote, so start one.
   task automatic set_row_width(logic [CFG_W-1:0] w);
      wait_drained();
      apb_write(ROW_WIDTH_ADDR, DATA_W'(w));
      if (span_of(w) > cur_span) force_frame = 1'b1;
      cur_span = span_of(w);
   endtask

   // Receiver: stall a random number of cycles before each pixel while
   // drain_stalls is set, or take the long hold-off when the stimulus asks for it.
   initial begin
      int stall_len;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_len > 0) begin
            stall_len = long_hold_len;
            long_hold_len = 0;
         end else begin
            stall_len = drain_stalls ? $urandom_range(0, 12) : 0;
         end
         if (stall_len > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin
      logic [CFG_W-1:0] w;
      int               n;
      int               random_items;
      int               pause_at;
      req_ch.valid = 1'b0;
      req_ch.red = '0;
      req_ch.green = '0;
      req_ch.blue = '0;
      req_ch.frame_start = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes and single channels at the reset width.
      push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
      // Threshold edge: gray 128 goes white with a large negative error,
      // which the black pixel after it clamps at zero.
      push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(8'd127, 8'd127, 8'd127, 1'b0);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      // New frame in the middle of a row.
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

      // Width zero acts as one; the next pixel lands past the new row end.
      set_row_width(12'd0);
      push_pixel(8'd127, 8'd127, 8'd127, 1'b0);
      push_pixel(8'd127, 8'd127, 8'd127, 1'b0);
      push_pixel(8'd64, 8'd64, 8'd64, 1'b0);
      push_pixel(8'd200, 8'd200, 8'd200, 1'b0);

      // Two pixel rows: errors pass right, below and diagonally.
      set_row_width(12'd2);
      push_pixel(8'd130, 8'd130, 8'd130, 1'b0);
      push_pixel(8'd125, 8'd125, 8'd125, 1'b0);
      push_pixel(8'd120, 8'd120, 8'd120, 1'b0);
      push_pixel(8'd135, 8'd135, 8'd135, 1'b0);
      push_pixel(8'd128, 8'd127, 8'd129, 1'b0);
      push_pixel(8'd126, 8'd130, 8'd124, 1'b0);

      // Largest register value acts as the maximum row; run the start of a
      // long row, then narrow the width mid-row below.
      set_row_width(12'hFFF);
      for (int i = 0; i < 40; i++) push_random(1'b0);

      // Back pressure: hold the receiver off while pixels keep coming, so
      // the block fills and stalls its input. The column is already past
      // the new row end, so the first pixel here ends the long row.
      set_row_width(12'd8);
      feed_gaps = 1'b0;
      long_hold_len = 200;
      for (int i = 0; i < 60; i++) push_random(1'b0);
      // Pause the sender until every pixel is back, then resume mid-row.
      wait_drained();
      for (int i = 0; i < 20; i++) push_random(1'b0);
      feed_gaps = 1'b1;

      // Random phases: mostly narrow rows, one or more rows each, frames now
      // and then, idling on each side switched per phase.
      random_items = 0;
      while (random_items < 1500) begin
         case ($urandom_range(0, 9))
            0:       w = 12'd0;
            1:       w = 12'd1;
            2:       w = 12'd2;
            7, 8:    w = CFG_W'($urandom_range(17, 64));
            9:       w = CFG_W'($urandom_range(65, 200));
            default: w = CFG_W'($urandom_range(3, 16));
         endcase
         set_row_width(w);
         feed_gaps = ($urandom_range(0, 3) != 0);
         drain_stalls = ($urandom_range(0, 3) != 0);
         n = span_of(w) * $urandom_range(1, 3) + $urandom_range(0, span_of(w));
         if (n > 240) n = 240;
         pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
         for (int i = 0; i < n; i++) begin
            if (i == pause_at) wait_drained();
            push_random((i == 0 && $urandom_range(0, 3) == 0) || $urandom_range(0, 59) == 0);
         end
         random_items += n;
      end

      // Drain, let the pipeline settle, then give the verdict.
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("floyd_steinberg_dither_top test passed");
      else
         $display("floyd_steinberg_dither_top test failed");
      $finish;
   end

endmodule
